// ----- rtl/rhsv_pkg.sv -----
// Shared constants, sector codes and the divider pipeline word for the RGB to HSV converter.
// No dependencies; every other file of the converter refers to this package by scoped names.
`timescale 1ns / 1ps

package rhsv_pkg;

	// Component and hue scaling.
	localparam int COMPONENT_BITS    = 8;
	localparam int HUE_FRACTION_BITS = 4;
	localparam int COMP_MAX          = (1 << COMPONENT_BITS) - 1;
	localparam int HUE_SIXTY         = 60 * (1 << HUE_FRACTION_BITS);
	localparam int HUE_FULL_TURN     = 6 * HUE_SIXTY;

	// Output hue port width.
	localparam int HUE_W = 13;

	// Quotient and dividend widths of the two dividers.
	localparam int HUE_Q_W    = $clog2(HUE_SIXTY + 1);
	localparam int HUE_NUM_W  = COMPONENT_BITS + HUE_Q_W;
	localparam int SAT_NUM_W  = 2 * COMPONENT_BITS;
	localparam int HUE_CALC_W = HUE_Q_W + 4;

	// One quotient bit per stage for both dividers at once.
	localparam int DIV_STAGES = (HUE_Q_W > COMPONENT_BITS) ? HUE_Q_W : COMPONENT_BITS;

	// Edges from the accepting edge to the edge that takes the result.
	localparam int LATENCY = DIV_STAGES + 3;

	// Hue sector: which component is the largest.
	typedef enum logic [1:0] {
		SECTOR_RED,
		SECTOR_GREEN,
		SECTOR_BLUE
	} sector_t;

	// Word that travels down the divider pipeline.
	typedef struct packed {
		logic [HUE_NUM_W-1:0]      hue_rem;
		logic [COMPONENT_BITS-1:0] hue_den;
		logic [HUE_Q_W-1:0]        hue_q;
		logic [SAT_NUM_W-1:0]      sat_rem;
		logic [COMPONENT_BITS-1:0] sat_den;
		logic [COMPONENT_BITS-1:0] sat_q;
		logic                      neg;
		sector_t                   sector;
		logic [COMPONENT_BITS-1:0] val;
		logic                      defined;
	} div_word_t;

endpackage

// ----- rtl/rgb_to_hsv_converter_top.sv -----
// An accepted word passes the front-end stages, the divider stages and the output register.
// Throughput: one pixel per clock; busy stays low because the result side never stalls.
// The divider pipeline sets the depth: a hue and a saturation bit per stage until each is done.
// Reset clears every valid bit at once; no word in flight survives a reset.
// Depends on rhsv_pkg, rhsv_front, rhsv_divider and rhsv_back.
`timescale 1ns / 1ps

module rgb_to_hsv_converter_top (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic [rhsv_pkg::COMPONENT_BITS-1:0] red,
	input  logic [rhsv_pkg::COMPONENT_BITS-1:0] green,
	input  logic [rhsv_pkg::COMPONENT_BITS-1:0] blue,
	output logic                                done,
	output logic [rhsv_pkg::HUE_W-1:0]          hue,
	output logic [rhsv_pkg::COMPONENT_BITS-1:0] saturation,
	output logic [rhsv_pkg::COMPONENT_BITS-1:0] brightness,
	output logic                                hue_defined
);

	// The pipeline advances every cycle, so a new pixel is always welcome.
	assign busy = 1'b0;

	logic                accept;
	logic                front_valid, div_valid;
	rhsv_pkg::div_word_t front_word, div_word;

	assign accept = start & ~busy;

	rhsv_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (accept),
		.red      (red),
		.green    (green),
		.blue     (blue),
		.valid_s2 (front_valid),
		.word_s2  (front_word)
	);

	rhsv_divider u_divider (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (front_valid),
		.in_word   (front_word),
		.out_valid (div_valid),
		.out_word  (div_word)
	);

	rhsv_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (div_valid),
		.in_word     (div_word),
		.done        (done),
		.hue         (hue),
		.saturation  (saturation),
		.brightness  (brightness),
		.hue_defined (hue_defined)
	);

	// Every accepted pixel leaves after exactly the pipeline latency.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##(rhsv_pkg::LATENCY) done)
		else $error("accepted pixel did not produce a result at the expected edge");

	// A colored pixel always has nonzero saturation.
	a_sat_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && hue_defined) |-> (saturation != '0))
		else $error("defined hue with zero saturation");

	// A grey pixel reports zero hue and zero saturation.
	a_grey: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !hue_defined) |-> (hue == '0 && saturation == '0))
		else $error("grey pixel with nonzero hue or saturation");

	// Hue stays below one full turn after the wrap.
	a_hue_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (hue < rhsv_pkg::HUE_W'(rhsv_pkg::HUE_FULL_TURN)))
		else $error("hue outside one full turn");

endmodule

// ----- rtl/rhsv_front.sv -----
// Front end of the RGB to HSV converter: max, min, sector and difference, then spread and dividends.
// Depends on rhsv_pkg for widths, sector codes and the divider word type.
`timescale 1ns / 1ps

module rhsv_front (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	input  logic [rhsv_pkg::COMPONENT_BITS-1:0] red,
	input  logic [rhsv_pkg::COMPONENT_BITS-1:0] green,
	input  logic [rhsv_pkg::COMPONENT_BITS-1:0] blue,
	output logic                               valid_s2,
	output rhsv_pkg::div_word_t                word_s2
);

	localparam int CB  = rhsv_pkg::COMPONENT_BITS;
	localparam int HNW = rhsv_pkg::HUE_NUM_W;
	localparam int SNW = rhsv_pkg::SAT_NUM_W;

	// Stage 1 combinational: largest, smallest, sector and signed difference.
	logic [CB-1:0]          mx, mn;
	rhsv_pkg::sector_t      sector;
	logic signed [CB:0]     diff;

	always_comb begin
		if (red >= green && red >= blue) begin
			sector = rhsv_pkg::SECTOR_RED;
			mx     = red;
			diff   = $signed({1'b0, green}) - $signed({1'b0, blue});
		end else if (green >= blue) begin
			sector = rhsv_pkg::SECTOR_GREEN;
			mx     = green;
			diff   = $signed({1'b0, blue}) - $signed({1'b0, red});
		end else begin
			sector = rhsv_pkg::SECTOR_BLUE;
			mx     = blue;
			diff   = $signed({1'b0, red}) - $signed({1'b0, green});
		end
		mn = red;
		if (green < mn) begin
			mn = green;
		end
		if (blue < mn) begin
			mn = blue;
		end
	end

	// Stage 1 registers.
	logic                   valid_s1;
	logic [CB-1:0]          mx_s1, mn_s1;
	rhsv_pkg::sector_t      sector_s1;
	logic signed [CB:0]     diff_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		mx_s1     <= mx;
		mn_s1     <= mn;
		sector_s1 <= sector;
		diff_s1   <= diff;
	end

	// Stage 2 combinational: spread, magnitude of the difference and both dividends.
	logic [CB-1:0]  delta;
	logic [CB:0]    diff_abs_w;
	logic [CB-1:0]  diff_abs;
	logic           neg;
	rhsv_pkg::div_word_t word;

	always_comb begin
		delta      = mx_s1 - mn_s1;
		neg        = diff_s1[CB];
		diff_abs_w = neg ? $unsigned(-diff_s1) : $unsigned(diff_s1);
		diff_abs   = diff_abs_w[CB-1:0];

		word         = '0;
		word.hue_rem = HNW'(diff_abs) * HNW'(rhsv_pkg::HUE_SIXTY);
		word.hue_den = delta;
		word.sat_rem = (SNW'(delta) << CB) - SNW'(delta);
		word.sat_den = mx_s1;
		word.neg     = neg;
		word.sector  = sector_s1;
		word.val     = mx_s1;
		word.defined = (delta != '0);
	end

	// Stage 2 registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		word_s2 <= word;
	end

endmodule

// ----- rtl/rhsv_divider.sv -----
// Pipelined restoring divider pair: one quotient bit of saturation and of hue per stage until each is complete.
// Depends on rhsv_pkg for the divider word type and the stage count.
`timescale 1ns / 1ps

module rhsv_divider (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  rhsv_pkg::div_word_t in_word,
	output logic                out_valid,
	output rhsv_pkg::div_word_t out_word
);

	localparam int DS  = rhsv_pkg::DIV_STAGES;
	localparam int CB  = rhsv_pkg::COMPONENT_BITS;
	localparam int QW  = rhsv_pkg::HUE_Q_W;
	localparam int HNW = rhsv_pkg::HUE_NUM_W;
	localparam int SNW = rhsv_pkg::SAT_NUM_W;

	logic                valid_s [DS];
	rhsv_pkg::div_word_t div_s   [DS];

	for (genvar k = 0; k < DS; k++) begin : g_step
		rhsv_pkg::div_word_t cur, nxt;
		logic                cur_valid;
		logic [HNW-1:0]      hue_rem_n;
		logic [QW-1:0]       hue_q_n;
		logic [SNW-1:0]      sat_rem_n;
		logic [CB-1:0]       sat_q_n;

		// Stage input: the block input for the first step, the previous stage otherwise.
		if (k == 0) begin : g_first
			assign cur       = in_word;
			assign cur_valid = in_valid;
		end else begin : g_next
			assign cur       = div_s[k-1];
			assign cur_valid = valid_s[k-1];
		end

		// Hue quotient bit, most significant first.
		if (k < QW) begin : g_hue
			localparam int HSH = QW - 1 - k;
			logic [HNW-1:0] hue_sub;
			assign hue_sub = HNW'(cur.hue_den) << HSH;
			always_comb begin
				hue_rem_n = cur.hue_rem;
				hue_q_n   = cur.hue_q;
				if (cur.hue_rem >= hue_sub) begin
					hue_rem_n     = cur.hue_rem - hue_sub;
					hue_q_n[HSH]  = 1'b1;
				end
			end
		end else begin : g_hue_idle
			assign hue_rem_n = cur.hue_rem;
			assign hue_q_n   = cur.hue_q;
		end

		// Saturation quotient bit, most significant first.
		if (k < CB) begin : g_sat
			localparam int SSH = CB - 1 - k;
			logic [SNW-1:0] sat_sub;
			assign sat_sub = SNW'(cur.sat_den) << SSH;
			always_comb begin
				sat_rem_n = cur.sat_rem;
				sat_q_n   = cur.sat_q;
				if (cur.sat_rem >= sat_sub) begin
					sat_rem_n     = cur.sat_rem - sat_sub;
					sat_q_n[SSH]  = 1'b1;
				end
			end
		end else begin : g_sat_idle
			assign sat_rem_n = cur.sat_rem;
			assign sat_q_n   = cur.sat_q;
		end

		// Merge the updated divider fields into the word.
		always_comb begin
			nxt         = cur;
			nxt.hue_rem = hue_rem_n;
			nxt.hue_q   = hue_q_n;
			nxt.sat_rem = sat_rem_n;
			nxt.sat_q   = sat_q_n;
		end

		// Stage registers.
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[k] <= 1'b0;
			end else begin
				valid_s[k] <= cur_valid;
			end
		end

		always_ff @(posedge clk) begin
			div_s[k] <= nxt;
		end
	end

	assign out_valid = valid_s[DS-1];
	assign out_word  = div_s[DS-1];

endmodule

// ----- rtl/rhsv_back.sv -----
// Back end of the RGB to HSV converter: hue assembly with wrap, grey handling and output registers.
// Depends on rhsv_pkg for widths, sector codes and the divider word type.
`timescale 1ns / 1ps

module rhsv_back (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	input  rhsv_pkg::div_word_t                 in_word,
	output logic                                done,
	output logic [rhsv_pkg::HUE_W-1:0]          hue,
	output logic [rhsv_pkg::COMPONENT_BITS-1:0] saturation,
	output logic [rhsv_pkg::COMPONENT_BITS-1:0] brightness,
	output logic                                hue_defined
);

	localparam int HCW = rhsv_pkg::HUE_CALC_W;
	localparam int HW  = rhsv_pkg::HUE_W;

	localparam logic signed [HCW-1:0] BASE_GREEN = HCW'(2 * rhsv_pkg::HUE_SIXTY);
	localparam logic signed [HCW-1:0] BASE_BLUE  = HCW'(4 * rhsv_pkg::HUE_SIXTY);
	localparam logic signed [HCW-1:0] FULL_TURN  = HCW'(rhsv_pkg::HUE_FULL_TURN);

	// Sector base plus or minus the quotient, wrapped once into a full turn.
	logic signed [HCW-1:0] base, mag, sum;

	always_comb begin
		unique case (in_word.sector)
			rhsv_pkg::SECTOR_RED:   base = '0;
			rhsv_pkg::SECTOR_GREEN: base = BASE_GREEN;
			rhsv_pkg::SECTOR_BLUE:  base = BASE_BLUE;
			default:                base = '0;
		endcase
		mag = $signed(HCW'(in_word.hue_q));
		sum = in_word.neg ? (base - mag) : (base + mag);
		if (sum < 0) begin
			sum = sum + FULL_TURN;
		end
	end

	// Output registers; a grey pixel forces hue and saturation to zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		hue         <= in_word.defined ? HW'($unsigned(sum)) : '0;
		saturation  <= in_word.defined ? in_word.sat_q : '0;
		brightness  <= in_word.val;
		hue_defined <= in_word.defined;
	end

endmodule

// ----- tb/tb_rgb_to_hsv_converter_top.sv -----
// Self-checking testbench for rgb_to_hsv_converter_top: pixels go in, HSV words come out.
// A built-in predictor computes each word; depends on rhsv_pkg and the converter RTL.
`timescale 1ns / 1ps

module tb_rgb_to_hsv_converter_top;

	localparam int CB             = rhsv_pkg::COMPONENT_BITS;
	localparam int HW             = rhsv_pkg::HUE_W;
	localparam int WATCHDOG_LIMIT = 2000;

	// One HSV word as the converter presents it.
	typedef struct packed {
		logic [HW-1:0] hue;
		logic [CB-1:0] saturation;
		logic [CB-1:0] brightness;
		logic          hue_defined;
	} hsv_word_t;

	logic          clk = 1'b0;
	logic          arst_n = 1'b0;
	logic          start = 1'b0;
	logic [CB-1:0] red = '0;
	logic [CB-1:0] green = '0;
	logic [CB-1:0] blue = '0;
	logic          busy;
	logic          done;
	logic [HW-1:0] hue;
	logic [CB-1:0] saturation;
	logic [CB-1:0] brightness;
	logic          hue_defined;

	hsv_word_t expected_hsv[$];
	int        mismatches = 0;
	int        quiet_cycles = 0;
	int        send_idle_pct = 0;

	rgb_to_hsv_converter_top dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.red         (red),
		.green       (green),
		.blue        (blue),
		.done        (done),
		.hue         (hue),
		.saturation  (saturation),
		.brightness  (brightness),
		.hue_defined (hue_defined)
	);

	// Clock with a 12 ns period.
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Fixed-point HSV of one pixel.
	function automatic hsv_word_t hsv_of(input logic [CB-1:0] r, input logic [CB-1:0] g,
			input logic [CB-1:0] b);
		int                 rv;
		int                 gv;
		int                 bv;
		int                 top;
		int                 bottom;
		int                 spread;
		int                 diff;
		int                 angle;
		rhsv_pkg::sector_t  sector;
		hsv_word_t          w;
		rv = int'(r);
		gv = int'(g);
		bv = int'(b);
		top = rv;
		bottom = rv;
		if (gv > top) top = gv;
		if (bv > top) top = bv;
		if (gv < bottom) bottom = gv;
		if (bv < bottom) bottom = bv;
		spread = top - bottom;
		w = '0;
		w.brightness = top[CB-1:0];
		// A grey pixel has no hue and no saturation.
		if (spread != 0) begin
			w.saturation = CB'((rhsv_pkg::COMP_MAX * spread) / top);
			if (rv >= top)
				sector = rhsv_pkg::SECTOR_RED;
			else if (gv >= top)
				sector = rhsv_pkg::SECTOR_GREEN;
			else
				sector = rhsv_pkg::SECTOR_BLUE;
			case (sector)
				rhsv_pkg::SECTOR_RED: begin
					angle = 0;
					diff = gv - bv;
				end
				rhsv_pkg::SECTOR_GREEN: begin
					angle = 2 * rhsv_pkg::HUE_SIXTY;
					diff = bv - rv;
				end
				default: begin
					angle = 4 * rhsv_pkg::HUE_SIXTY;
					diff = rv - gv;
				end
			endcase
			// Division truncates toward zero before the wrap.
			angle = angle + (rhsv_pkg::HUE_SIXTY * diff) / spread;
			if (angle < 0)
				angle = angle + rhsv_pkg::HUE_FULL_TURN;
			w.hue = angle[HW-1:0];
			w.hue_defined = 1'b1;
		end
		return w;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("%0t ns: mismatch: %s", $time, msg);
		mismatches++;
	endtask

	// Sends one pixel word, with random idle cycles ahead of it, and returns once it is taken.
	task automatic send_pixel(input logic [CB-1:0] r, input logic [CB-1:0] g,
			input logic [CB-1:0] b);
		bit idled;
		idled = 1'b0;
		while ($urandom_range(99) < send_idle_pct) begin
			if (!idled)
				start <= 1'b0;
			idled = 1'b1;
			@(posedge clk);
		end
		start <= 1'b1;
		red <= r;
		green <= g;
		blue <= b;
		@(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	// Pixel with a random shape: greys, tied maxima, narrow spreads, extreme components.
	task automatic send_random_pixel();
		logic [CB-1:0] c [3];
		logic [CB-1:0] m;
		logic [CB-1:0] o;
		int            k;
		int            i;
		int            step;
		for (i = 0; i < 3; i++)
			c[i] = CB'($urandom_range(rhsv_pkg::COMP_MAX));
		case ($urandom_range(9))
			0: begin
				c[1] = c[0];
				c[2] = c[0];
			end
			1: begin
				m = CB'($urandom_range(rhsv_pkg::COMP_MAX));
				o = CB'($urandom_range(int'(m)));
				k = $urandom_range(2);
				for (i = 0; i < 3; i++)
					c[i] = (i == k) ? o : m;
			end
			2: begin
				for (i = 1; i < 3; i++) begin
					step = $urandom_range(2);
					c[i] = (int'(c[0]) >= step) ? c[0] - CB'(step) : c[0];
				end
				k = $urandom_range(2);
				m = c[k];
				c[k] = c[0];
				c[0] = m;
			end
			3: begin
				for (i = 0; i < 3; i++) begin
					case ($urandom_range(2))
						0: c[i] = '0;
						1: c[i] = CB'(rhsv_pkg::COMP_MAX);
						default: ;
					endcase
				end
			end
			default: ;
		endcase
		send_pixel(c[0], c[1], c[2]);
	endtask

	// Corners: black, white, primaries, secondaries, ties, wrap of a negative hue.
	task automatic test_directed_pixels();
		send_idle_pct = 0;
		send_pixel(8'd0, 8'd0, 8'd0);
		send_pixel(8'd255, 8'd255, 8'd255);
		send_pixel(8'd128, 8'd128, 8'd128);
		send_pixel(8'd255, 8'd0, 8'd0);
		send_pixel(8'd0, 8'd255, 8'd0);
		send_pixel(8'd0, 8'd0, 8'd255);
		send_pixel(8'd255, 8'd255, 8'd0);
		send_pixel(8'd0, 8'd255, 8'd255);
		send_pixel(8'd255, 8'd0, 8'd255);
		send_pixel(8'd255, 8'd0, 8'd1);
		send_pixel(8'd1, 8'd0, 8'd0);
		send_pixel(8'd255, 8'd254, 8'd254);
		send_pixel(8'd0, 8'd1, 8'd0);
		send_pixel(8'd0, 8'd0, 8'd1);
		send_pixel(8'd200, 8'd200, 8'd10);
		send_pixel(8'd10, 8'd200, 8'd200);
		send_pixel(8'd200, 8'd10, 8'd200);
		send_pixel(8'd170, 8'd85, 8'd0);
		send_pixel(8'd85, 8'd170, 8'd0);
		send_pixel(8'd0, 8'd85, 8'd170);
		send_pixel(8'd3, 8'd1, 8'd2);
		send_pixel(8'd254, 8'd255, 8'd253);
	endtask

	// A full-rate stream of random pixels.
	task automatic test_back_to_back(input int count);
		int n;
		send_idle_pct = 0;
		for (n = 0; n < count; n++)
			send_random_pixel();
	endtask

	// Random pixels with the sender idle in most cycles.
	task automatic test_sparse_input(input int count);
		int n;
		send_idle_pct = 63;
		for (n = 0; n < count; n++)
			send_random_pixel();
	endtask

	// Random pixels with occasional sender gaps.
	task automatic test_light_idling(input int count);
		int n;
		send_idle_pct = 10;
		for (n = 0; n < count; n++)
			send_random_pixel();
	endtask

	// Predicts each accepted pixel, checks each result word, and runs the watchdog.
	always @(posedge clk) begin
		hsv_word_t want;
		if (arst_n) begin
			if (done) begin
				if (expected_hsv.size() == 0) begin
					report_mismatch("result word with no pixel pending");
				end else begin
					want = expected_hsv.pop_front();
					if (hue !== want.hue)
						report_mismatch($sformatf("hue %0d, expected %0d", hue, want.hue));
					if (saturation !== want.saturation)
						report_mismatch($sformatf("saturation %0d, expected %0d",
							saturation, want.saturation));
					if (brightness !== want.brightness)
						report_mismatch($sformatf("brightness %0d, expected %0d",
							brightness, want.brightness));
					if (hue_defined !== want.hue_defined)
						report_mismatch($sformatf("hue_defined %0b, expected %0b",
							hue_defined, want.hue_defined));
				end
			end
			if (start && !busy)
				expected_hsv.push_back(hsv_of(red, green, blue));
			// The watchdog counts cycles in which no word moves on either side.
			if (done || (start && !busy))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("FAILURE");
				$finish;
			end
		end
	end

	// Test sequence.
	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		test_directed_pixels();
		test_back_to_back(400);
		test_sparse_input(200);
		test_light_idling(200);
		start <= 1'b0;
		while (expected_hsv.size() != 0)
			@(posedge clk);
		repeat (rhsv_pkg::LATENCY + 4) @(posedge clk);
		if (mismatches == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

// ----- files.f -----
rtl/rhsv_pkg.sv
rtl/rhsv_front.sv
rtl/rhsv_divider.sv
rtl/rhsv_back.sv
rtl/rgb_to_hsv_converter_top.sv
tb/tb_rgb_to_hsv_converter_top.sv
